// ===== design/uue_pkg.sv =====
// ----------------------------------------------------------------------------
// uue_pkg
// shared types, constants and helper functions of the uri percent encoder
// ----------------------------------------------------------------------------
package uue_pkg;

    localparam int UNIT_W = 16;
    localparam int MASK_W = 5;
    localparam int CP_W   = 21;
    localparam int OCT_W  = 8;
    localparam int N_OCT  = 4;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [MASK_W-1:0] MASK_RESET = 5'd13;

    // character class bits
    localparam logic [MASK_W-1:0] CLS_ALPHA    = 5'b00001;
    localparam logic [MASK_W-1:0] CLS_RESERVED = 5'b00010;
    localparam logic [MASK_W-1:0] CLS_MARK     = 5'b00100;
    localparam logic [MASK_W-1:0] CLS_DIGIT    = 5'b01000;
    localparam logic [MASK_W-1:0] CLS_HASH     = 5'b10000;

    localparam logic [UNIT_W-1:0] PCT_CHAR = 16'h0025;

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_ERR,
        CMD_ENC
    } cmd_kind_t;

    // one queued command: what the back end must emit for one item
    typedef struct packed {
        cmd_kind_t       kind;
        logic [CP_W-1:0] value;     // passthrough unit or code point
        logic [1:0]      last_oct;  // number of utf-8 octets minus one
        logic            eos;
    } cmd_t;

    function automatic logic [MASK_W-1:0] char_class(input logic [6:0] c);
        logic [MASK_W-1:0] k;
        k = '0;
        if ((c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A))
            k = k | CLS_ALPHA;
        if (c >= 7'h30 && c <= 7'h39)
            k = k | CLS_DIGIT;
        if (c == 7'h23)
            k = k | CLS_HASH;
        case (c) inside
            7'h3B, 7'h2F, 7'h3F, 7'h3A, 7'h40, 7'h26, 7'h3D, 7'h2B, 7'h24, 7'h2C:
                k = k | CLS_RESERVED;
            7'h2D, 7'h5F, 7'h2E, 7'h21, 7'h7E, 7'h2A, 7'h27, 7'h28, 7'h29:
                k = k | CLS_MARK;
            default:
                k = k;
        endcase
        return k;
    endfunction

    // uppercase ascii hex digit of a nibble
    function automatic logic [UNIT_W-1:0] hex_digit(input logic [3:0] n);
        logic [UNIT_W-1:0] d;
        if (n < 4'd10)
            d = 16'h0030 + {12'd0, n};
        else
            d = 16'h0037 + {12'd0, n};
        return d;
    endfunction

endpackage

// ===== design/uue_if.sv =====
// ----------------------------------------------------------------------------
// uue channel interfaces
// valid/ready channels for code units, output characters and configuration
// ----------------------------------------------------------------------------
interface uue_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        end_of_string;

    modport source (output valid, code_unit, end_of_string, input ready);
    modport sink   (input valid, code_unit, end_of_string, output ready);
endinterface

interface uue_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_char;
    logic        encode_error;
    logic        last_of_item;
    logic        string_done;

    modport source (output valid, out_char, encode_error, last_of_item, string_done,
                    input ready);
    modport sink   (input valid, out_char, encode_error, last_of_item, string_done,
                    output ready);
endinterface

interface uue_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] unescaped_class_mask;

    modport source (output valid, unescaped_class_mask, input ready);
    modport sink   (input valid, unescaped_class_mask, output ready);
endinterface

// ===== design/uue_queue.sv =====
// ----------------------------------------------------------------------------
// uue_queue
// small command fifo between classifier and emitter
// ----------------------------------------------------------------------------
module uue_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  uue_pkg::cmd_t wdata,
    output logic          full,
    input  logic          pop,
    output uue_pkg::cmd_t rdata,
    output logic          empty
);
    import uue_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wdata;
    end

endmodule

// ===== design/uue_front.sv =====
// ----------------------------------------------------------------------------
// uue_front
// accepts code units, tracks surrogate and failure state, queues commands
// ----------------------------------------------------------------------------
module uue_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [uue_pkg::MASK_W-1:0] mask,
    uue_in_if.sink                     units,
    input  logic                       q_full,
    output logic                       push,
    output uue_pkg::cmd_t              cmd
);
    import uue_pkg::*;

    logic [9:0] held_reg;
    logic [9:0] held_next;
    logic       pending_reg;
    logic       pending_next;
    logic       failed_reg;
    logic       failed_next;

    logic              accept;
    logic              emit;
    logic              err;
    logic              is_low;
    logic              is_high;
    logic              pass;
    logic [UNIT_W-1:0] c;
    logic              e;

    assign c       = units.code_unit;
    assign e       = units.end_of_string;
    assign is_low  = (c[15:10] == 6'b110111);
    assign is_high = (c[15:10] == 6'b110110);
    assign pass    = (c[15:7] == '0) && ((char_class(c[6:0]) & mask) != '0);

    assign units.ready = !q_full;
    assign accept      = units.valid && !q_full;
    assign push        = accept && emit;

    always_comb
    begin
        held_next    = held_reg;
        pending_next = pending_reg;
        failed_next  = failed_reg;
        emit         = 1'b0;
        err          = 1'b0;
        cmd.kind     = CMD_ENC;
        cmd.value    = {5'd0, c};
        cmd.eos      = e;
        if (c <= 16'h007F)
            cmd.last_oct = 2'd0;
        else if (c <= 16'h07FF)
            cmd.last_oct = 2'd1;
        else
            cmd.last_oct = 2'd2;

        if (failed_reg)
        begin
            // drop the rest of a broken string
            if (e)
                failed_next = 1'b0;
        end
        else if (pending_reg)
        begin
            pending_next = 1'b0;
            held_next    = '0;
            if (is_low)
            begin
                emit         = 1'b1;
                cmd.value    = {1'b0, held_reg, c[9:0]} + 21'h010000;
                cmd.last_oct = 2'd3;
            end
            else
                err = 1'b1;
        end
        else if (pass)
        begin
            emit     = 1'b1;
            cmd.kind = CMD_PASS;
        end
        else if (is_low)
            err = 1'b1;
        else if (is_high)
        begin
            if (e)
                err = 1'b1;
            else
            begin
                held_next    = c[9:0];
                pending_next = 1'b1;
            end
        end
        else
            emit = 1'b1;

        if (err)
        begin
            emit     = 1'b1;
            cmd.kind = CMD_ERR;
            if (!e)
                failed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            pending_reg <= 1'b0;
            failed_reg  <= 1'b0;
        end
        else if (accept)
        begin
            held_reg    <= held_next;
            pending_reg <= pending_next;
            failed_reg  <= failed_next;
        end
    end

endmodule

// ===== design/uue_back.sv =====
// ----------------------------------------------------------------------------
// uue_back
// expands queued commands into output characters, one beat per ready cycle
// ----------------------------------------------------------------------------
module uue_back (
    input  logic          clk,
    input  logic          rst_n,
    input  uue_pkg::cmd_t rdata,
    input  logic          empty,
    output logic          pop,
    uue_out_if.source     chars
);
    import uue_pkg::*;

    typedef enum logic [1:0] {
        PH_PCT,
        PH_HI,
        PH_LO
    } phase_t;

    logic                        busy_reg;
    cmd_kind_t                   kind_reg;
    logic [N_OCT-1:0][OCT_W-1:0] oct_reg;
    logic [UNIT_W-1:0]           char_reg;
    logic [1:0]                  last_oct_reg;
    logic [1:0]                  idx_reg;
    phase_t                      phase_reg;
    logic                        eos_reg;

    logic              ovalid_reg;
    logic [UNIT_W-1:0] ochar_reg;
    logic              oerr_reg;
    logic              olast_reg;
    logic              odone_reg;

    logic                        can_load;
    logic                        step;
    logic                        cur_last;
    logic [OCT_W-1:0]            cur_oct;
    logic [UNIT_W-1:0]           res_char;
    logic                        res_err;
    logic [N_OCT-1:0][OCT_W-1:0] new_oct;
    logic [CP_W-1:0]             v;

    assign v = rdata.value;

    // utf-8 octets of the head command, first octet in slot 0
    always_comb
    begin
        new_oct = '0;
        unique case (rdata.last_oct)
            2'd0:
                new_oct[0] = {1'b0, v[6:0]};
            2'd1:
            begin
                new_oct[0] = {3'b110, v[10:6]};
                new_oct[1] = {2'b10, v[5:0]};
            end
            2'd2:
            begin
                new_oct[0] = {4'b1110, v[15:12]};
                new_oct[1] = {2'b10, v[11:6]};
                new_oct[2] = {2'b10, v[5:0]};
            end
            default:
            begin
                new_oct[0] = {5'b11110, v[20:18]};
                new_oct[1] = {2'b10, v[17:12]};
                new_oct[2] = {2'b10, v[11:6]};
                new_oct[3] = {2'b10, v[5:0]};
            end
        endcase
    end

    assign cur_oct  = oct_reg[idx_reg];
    assign cur_last = (kind_reg != CMD_ENC) || ((idx_reg == last_oct_reg) && (phase_reg == PH_LO));
    assign can_load = !ovalid_reg || chars.ready;
    assign step     = busy_reg && can_load;
    assign pop      = !empty && (!busy_reg || (step && cur_last));

    always_comb
    begin
        res_err  = 1'b0;
        res_char = char_reg;
        unique case (kind_reg)
            CMD_PASS:
                res_char = char_reg;
            CMD_ERR:
            begin
                res_char = '0;
                res_err  = 1'b1;
            end
            CMD_ENC:
            begin
                unique case (phase_reg)
                    PH_PCT:  res_char = PCT_CHAR;
                    PH_HI:   res_char = hex_digit(cur_oct[7:4]);
                    default: res_char = hex_digit(cur_oct[3:0]);
                endcase
            end
            default:
                res_char = '0;
        endcase
    end

    assign chars.valid        = ovalid_reg;
    assign chars.out_char     = ochar_reg;
    assign chars.encode_error = oerr_reg;
    assign chars.last_of_item = olast_reg;
    assign chars.string_done  = odone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            phase_reg    <= PH_PCT;
            ovalid_reg   <= 1'b0;
            kind_reg     <= CMD_PASS;
            oct_reg      <= '0;
            char_reg     <= '0;
            last_oct_reg <= '0;
            eos_reg      <= 1'b0;
            ochar_reg    <= '0;
            oerr_reg     <= 1'b0;
            olast_reg    <= 1'b0;
            odone_reg    <= 1'b0;
        end
        else
        begin
            if (step)
                ovalid_reg <= 1'b1;
            else if (chars.ready)
                ovalid_reg <= 1'b0;

            if (pop)
            begin
                busy_reg     <= 1'b1;
                idx_reg      <= '0;
                phase_reg    <= PH_PCT;
                kind_reg     <= rdata.kind;
                oct_reg      <= new_oct;
                char_reg     <= v[UNIT_W-1:0];
                last_oct_reg <= rdata.last_oct;
                eos_reg      <= rdata.eos;
            end
            else if (step)
            begin
                if (cur_last)
                    busy_reg <= 1'b0;
                else if (phase_reg == PH_LO)
                begin
                    phase_reg <= PH_PCT;
                    idx_reg   <= idx_reg + 1'b1;
                end
                else if (phase_reg == PH_PCT)
                    phase_reg <= PH_HI;
                else
                    phase_reg <= PH_LO;
            end

            if (step)
            begin
                ochar_reg <= res_char;
                oerr_reg  <= res_err;
                olast_reg <= cur_last;
                odone_reg <= cur_last && eos_reg;
            end
        end
    end

endmodule

// ===== design/uri_utf8_percent_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// uri_utf8_percent_encoder_unit
// percent encoder turning utf-16 code units into uri-safe characters
// ----------------------------------------------------------------------------
// usage
//   units: one utf-16 code unit per beat, end_of_string on the last unit
//   chars: one output character per beat; last_of_item closes the
//     characters of one unit, string_done closes the string
//   cfg: writes unescaped_class_mask, always ready; write only while idle
// timing
//   a unit is classified in the cycle it is accepted and queued; the
//   emitter pops it from the queue, loads it into its working registers
//   and then registers its first character in the output register
//   the emitter sends one character per cycle while the receiver is ready;
//   a unit yields 1 character (passthrough or error) or 3, 6, 9 or 12
//   (1 to 4 utf-8 octets); held high surrogates and dropped units yield none
//   the four-entry command queue lets units enter while characters drain
// reset and stall
//   reset empties the queue, clears surrogate and failure state and loads
//   the class mask with alpha, mark and digit
//   a stalled receiver holds the output register; once the queue is full,
//   units.ready drops until the emitter frees an entry
// ----------------------------------------------------------------------------
module uri_utf8_percent_encoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    uue_in_if.sink     units,
    uue_out_if.source  chars,
    uue_cfg_if.sink    cfg
);
    import uue_pkg::*;

    logic [MASK_W-1:0] mask_reg;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    cmd_t              q_wdata;
    cmd_t              q_rdata;

    // configuration register, written in a single beat
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= MASK_RESET;
        else if (cfg.valid)
            mask_reg <= cfg.unescaped_class_mask;
    end

    // front end: classification and surrogate tracking
    uue_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .mask   (mask_reg),
        .units  (units),
        .q_full (q_full),
        .push   (q_push),
        .cmd    (q_wdata)
    );

    // command queue decoupling both sides
    uue_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // back end: character emission
    uue_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .rdata (q_rdata),
        .empty (q_empty),
        .pop   (q_pop),
        .chars (chars)
    );

`ifndef ASSERT_OFF
    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue reports full and empty together");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty command queue");

    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && chars.encode_error) |-> (chars.last_of_item && chars.out_char == '0))
        else $error("error beat is not a lone zero character");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && chars.string_done) |-> chars.last_of_item)
        else $error("string closed before the last beat of its unit");
`endif

endmodule
